// ----- rtl/preshower_cpv_cluster_match_macros.svh -----
// Assertion macros for the preshower / veto cluster matcher.
// Used by the top level; expects signals clk and rst in scope.
`ifndef PRESHOWER_CPV_CLUSTER_MATCH_MACROS_SVH
`define PRESHOWER_CPV_CLUSTER_MATCH_MACROS_SVH

// same-cycle implication
`define PSCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pscm assertion failed");

// next-cycle implication
`define PSCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pscm assertion failed");

`endif

// ----- rtl/pscm_pkg.sv -----
// Package for the preshower / veto cluster matcher: sizes, sequencer states,
// pad and grid address helpers. No dependencies.
`timescale 1ns / 1ps

package pscm_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int GRID_X       = 48;
  localparam int GRID_Y       = 96;
  localparam int GRID_CELLS   = GRID_X * GRID_Y;

  localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int PX_W   = $clog2(GRID_X);
  localparam int PY_W   = $clog2(GRID_Y);
  localparam int GA_W   = $clog2(GRID_CELLS);
  localparam int ADC_W  = 20;
  localparam int ENT_W  = 63;
  localparam int SORT_W = ADC_W + IDX_W;
  localparam int NB_LAST = 5;

  localparam logic [ADC_W-1:0] THRESH_RESET = 20'd4500;

  // grid cell bits
  localparam int G_HIT   = 0;
  localparam int G_CLAIM = 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_WAIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_ORD_RD,
    ST_ORD_WAIT,
    ST_PRE_WAIT,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_PRE_EMIT,
    ST_VETO_RD,
    ST_VETO_EMIT,
    ST_WIPE_RD,
    ST_WIPE_WR
  } state_t;

  // round to nearest pad, clamp to the grid
  function automatic logic [PX_W-1:0] pad_x(input logic [9:0] pos);
    logic [10:0] s;
    logic [6:0]  raw;
    s   = {1'b0, pos} + 11'd8;
    raw = s[10:4];
    if (raw > 7'(GRID_X - 1)) return PX_W'(GRID_X - 1);
    return raw[PX_W-1:0];
  endfunction

  function automatic logic [PY_W-1:0] pad_y(input logic [10:0] pos);
    logic [11:0] s;
    logic [7:0]  raw;
    s   = {1'b0, pos} + 12'd8;
    raw = s[11:4];
    if (raw > 8'(GRID_Y - 1)) return PY_W'(GRID_Y - 1);
    return raw[PY_W-1:0];
  endfunction

  // hexagonal neighbour k, dx = {1,0,-1,-1,0,1}
  function automatic logic [PX_W-1:0] nb_x(input logic [PX_W-1:0] c, input logic [2:0] k);
    logic [PX_W-1:0] r;
    r = c;
    case (k)
      3'd0, 3'd5: if (c != PX_W'(GRID_X - 1)) r = c + 1'b1;
      3'd2, 3'd3: if (c != '0) r = c - 1'b1;
      default:    r = c;
    endcase
    return r;
  endfunction

  // dy = {0,1,1,0,-1,-1}
  function automatic logic [PY_W-1:0] nb_y(input logic [PY_W-1:0] c, input logic [2:0] k);
    logic [PY_W-1:0] r;
    r = c;
    case (k)
      3'd1, 3'd2: if (c != PY_W'(GRID_Y - 1)) r = c + 1'b1;
      3'd4, 3'd5: if (c != '0) r = c - 1'b1;
      default:    r = c;
    endcase
    return r;
  endfunction

  function automatic logic [GA_W-1:0] grid_addr(input logic [PX_W-1:0] cx,
                                                input logic [PY_W-1:0] cy);
    return GA_W'(cx) * GA_W'(GRID_Y) + GA_W'(cy);
  endfunction

endpackage

// ----- rtl/pscm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/preshower_cpv_cluster_match.sv -----
// Preshower / veto cluster matcher, top level.
// Uses pscm_pkg, pscm_ram and preshower_cpv_cluster_match_macros.svh.
//
// Usage:
//  - Items enter on start when busy is low, one per cycle while loading.
//    Preshower and veto items share 64 slots; extra items are dropped and
//    every result of that batch carries overflow.
//  - An item with last_in_batch closes the batch; busy rises and the batch
//    is worked off: insertion sort of preshower items by ADC, then per
//    preshower item a probe of up to 6 neighbour pads, stopping at the
//    first unclaimed hit, then output of each veto item and a pass that
//    wipes the grid cell of each veto item.
//  - Results appear on result_valid, one cycle each; last_of_batch marks
//    the final one. The receiver cannot stall.
//  - The probe loop is bound by the single grid RAM read port and the
//    shared grid address unit (x*96 + y).
//  - After reset a clearing pass writes all 4608 grid cells with busy high;
//    cfg_we writes are taken at any time.
//  - adc_threshold (cfg_wdata) resets to 4500.
`timescale 1ns / 1ps
`include "preshower_cpv_cluster_match_macros.svh"

module preshower_cpv_cluster_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        plane,
  input  logic [4:0]  module_req,
  input  logic [9:0]  x_pos,
  input  logic [10:0] y_pos,
  input  logic [19:0] adc,
  input  logic [11:0] cell_count,
  input  logic [9:0]  radius,
  input  logic        last_in_batch,
  output logic        result_valid,
  output logic        out_plane,
  output logic [4:0]  out_module,
  output logic [9:0]  out_x,
  output logic [10:0] out_y,
  output logic [19:0] out_adc,
  output logic [11:0] out_cells,
  output logic [9:0]  out_radius,
  output logic        pid_flag,
  output logic        veto_matched,
  output logic        overflow,
  output logic        last_of_batch
);

  pscm_pkg::state_t state, state_next;

  logic [19:0]                  adc_threshold;
  logic [pscm_pkg::CNT_W-1:0]   pre_count, veto_count, idx;
  logic [pscm_pkg::IDX_W-1:0]   j;
  logic [2:0]                   k;
  logic [pscm_pkg::GA_W-1:0]    clr_cnt;
  logic [4:0]                   batch_module;
  logic                         dropped_flag;
  logic [pscm_pkg::ADC_W-1:0]   key;
  logic [pscm_pkg::ENT_W-1:0]   ent;
  logic                         matched;

  logic [pscm_pkg::CNT_W:0]     total;
  logic                         accept, room;
  logic [pscm_pkg::ENT_W-1:0]   in_ent;

  // RAM ports
  logic                         pre_we, veto_we, sort_we, grid_we;
  logic [pscm_pkg::IDX_W-1:0]   pre_raddr, veto_raddr, sort_raddr, sort_waddr;
  logic [pscm_pkg::ENT_W-1:0]   pre_rdata, veto_rdata;
  logic [pscm_pkg::SORT_W-1:0]  sort_wdata, sort_rdata;
  logic [pscm_pkg::GA_W-1:0]    grid_waddr, grid_ua;
  logic [1:0]                   grid_wdata, grid_rdata;

  // shared grid address unit operands
  logic [pscm_pkg::PX_W-1:0]    ux, ecx;
  logic [pscm_pkg::PY_W-1:0]    uy, ecy;

  logic                         sort_gt, probe_hit;

  assign total  = {1'b0, pre_count} + {1'b0, veto_count};
  assign accept = start && !busy;
  assign room   = total < (pscm_pkg::CNT_W + 1)'(pscm_pkg::MAX_CLUSTERS);
  assign in_ent = {radius, cell_count, adc, y_pos, x_pos};
  assign ecx    = pscm_pkg::pad_x(ent[9:0]);
  assign ecy    = pscm_pkg::pad_y(ent[20:10]);
  assign grid_ua = pscm_pkg::grid_addr(ux, uy);
  assign sort_gt = sort_rdata[pscm_pkg::SORT_W-1:pscm_pkg::IDX_W] > key;
  assign probe_hit = grid_rdata[pscm_pkg::G_HIT] && !grid_rdata[pscm_pkg::G_CLAIM];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pscm_pkg::ST_CLEAR:
        if (clr_cnt == pscm_pkg::GA_W'(pscm_pkg::GRID_CELLS - 1))
          state_next = pscm_pkg::ST_IDLE;
      pscm_pkg::ST_IDLE:
        if (start && last_in_batch) state_next = pscm_pkg::ST_KEY_RD;
      pscm_pkg::ST_KEY_RD:
        state_next = (idx == pre_count) ? pscm_pkg::ST_ORD_RD : pscm_pkg::ST_KEY_WAIT;
      pscm_pkg::ST_KEY_WAIT: state_next = pscm_pkg::ST_SORT_RD;
      pscm_pkg::ST_SORT_RD:
        state_next = (j == '0) ? pscm_pkg::ST_KEY_RD : pscm_pkg::ST_SORT_CMP;
      pscm_pkg::ST_SORT_CMP:
        state_next = sort_gt ? pscm_pkg::ST_SORT_RD : pscm_pkg::ST_KEY_RD;
      pscm_pkg::ST_ORD_RD:
        state_next = (idx == pre_count) ? pscm_pkg::ST_VETO_RD : pscm_pkg::ST_ORD_WAIT;
      pscm_pkg::ST_ORD_WAIT: state_next = pscm_pkg::ST_PRE_WAIT;
      pscm_pkg::ST_PRE_WAIT: state_next = pscm_pkg::ST_PROBE_RD;
      pscm_pkg::ST_PROBE_RD: state_next = pscm_pkg::ST_PROBE_CHK;
      pscm_pkg::ST_PROBE_CHK:
        state_next = (probe_hit || k == 3'(pscm_pkg::NB_LAST)) ?
                     pscm_pkg::ST_PRE_EMIT : pscm_pkg::ST_PROBE_RD;
      pscm_pkg::ST_PRE_EMIT: state_next = pscm_pkg::ST_ORD_RD;
      pscm_pkg::ST_VETO_RD:
        state_next = (idx == veto_count) ? pscm_pkg::ST_WIPE_RD : pscm_pkg::ST_VETO_EMIT;
      pscm_pkg::ST_VETO_EMIT: state_next = pscm_pkg::ST_VETO_RD;
      pscm_pkg::ST_WIPE_RD:
        state_next = (idx == veto_count) ? pscm_pkg::ST_IDLE : pscm_pkg::ST_WIPE_WR;
      pscm_pkg::ST_WIPE_WR: state_next = pscm_pkg::ST_WIPE_RD;
      default: state_next = pscm_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and memory controls
  always_comb begin
    busy       = (state != pscm_pkg::ST_IDLE);
    pre_we     = 1'b0;
    veto_we    = 1'b0;
    sort_we    = 1'b0;
    grid_we    = 1'b0;
    pre_raddr  = idx[pscm_pkg::IDX_W-1:0];
    veto_raddr = idx[pscm_pkg::IDX_W-1:0];
    sort_raddr = idx[pscm_pkg::IDX_W-1:0];
    sort_waddr = j;
    sort_wdata = {key, idx[pscm_pkg::IDX_W-1:0]};
    grid_wdata = 2'b00;
    grid_waddr = grid_ua;
    ux         = '0;
    uy         = '0;
    case (state)
      pscm_pkg::ST_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_cnt;
      end
      pscm_pkg::ST_IDLE: begin
        ux = pscm_pkg::pad_x(x_pos);
        uy = pscm_pkg::pad_y(y_pos);
        if (accept && room) begin
          pre_we     = !plane;
          veto_we    = plane;
          grid_we    = plane;
          grid_wdata = {1'b0, adc != 20'd0};
        end
      end
      pscm_pkg::ST_SORT_RD: begin
        sort_raddr = j - 1'b1;
        sort_we    = (j == '0);
      end
      pscm_pkg::ST_SORT_CMP: begin
        sort_we = 1'b1;
        if (sort_gt) sort_wdata = sort_rdata;
      end
      pscm_pkg::ST_ORD_WAIT: pre_raddr = sort_rdata[pscm_pkg::IDX_W-1:0];
      pscm_pkg::ST_PROBE_RD, pscm_pkg::ST_PROBE_CHK: begin
        ux = pscm_pkg::nb_x(ecx, k);
        uy = pscm_pkg::nb_y(ecy, k);
        if (state == pscm_pkg::ST_PROBE_CHK && probe_hit) begin
          grid_we    = 1'b1;
          grid_wdata = 2'b11;
        end
      end
      pscm_pkg::ST_WIPE_WR: begin
        ux      = pscm_pkg::pad_x(veto_rdata[9:0]);
        uy      = pscm_pkg::pad_y(veto_rdata[20:10]);
        grid_we = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pscm_pkg::ST_CLEAR;
      adc_threshold <= pscm_pkg::THRESH_RESET;
      pre_count     <= '0;
      veto_count    <= '0;
      idx           <= '0;
      j             <= '0;
      k             <= '0;
      clr_cnt       <= '0;
      batch_module  <= '0;
      dropped_flag  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == pscm_pkg::ST_PRE_EMIT) || (state == pscm_pkg::ST_VETO_EMIT);
      if (cfg_we) adc_threshold <= cfg_wdata;
      case (state)
        pscm_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        pscm_pkg::ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            if (!room) dropped_flag <= 1'b1;
            else begin
              if (total == '0) batch_module <= module_req;
              if (plane) veto_count <= veto_count + 1'b1;
              else       pre_count  <= pre_count + 1'b1;
            end
          end
        end
        pscm_pkg::ST_KEY_RD: if (idx == pre_count) idx <= '0;
        pscm_pkg::ST_KEY_WAIT: j <= idx[pscm_pkg::IDX_W-1:0];
        pscm_pkg::ST_SORT_RD: if (j == '0) idx <= idx + 1'b1;
        pscm_pkg::ST_SORT_CMP: begin
          if (sort_gt) j <= j - 1'b1;
          else idx <= idx + 1'b1;
        end
        pscm_pkg::ST_ORD_RD: if (idx == pre_count) idx <= '0;
        pscm_pkg::ST_PRE_WAIT: k <= '0;
        pscm_pkg::ST_PROBE_CHK: if (!probe_hit) k <= k + 1'b1;
        pscm_pkg::ST_PRE_EMIT: idx <= idx + 1'b1;
        pscm_pkg::ST_VETO_RD: if (idx == veto_count) idx <= '0;
        pscm_pkg::ST_VETO_EMIT: idx <= idx + 1'b1;
        pscm_pkg::ST_WIPE_RD: if (idx == veto_count) begin
          pre_count    <= '0;
          veto_count   <= '0;
          dropped_flag <= 1'b0;
        end
        pscm_pkg::ST_WIPE_WR: idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == pscm_pkg::ST_KEY_WAIT) key <= pre_rdata[40:21];
    if (state == pscm_pkg::ST_PRE_WAIT) begin
      ent     <= pre_rdata;
      matched <= 1'b0;
    end
    if (state == pscm_pkg::ST_PROBE_CHK && probe_hit) matched <= 1'b1;
    if (state == pscm_pkg::ST_PRE_EMIT || state == pscm_pkg::ST_VETO_EMIT) begin
      out_module <= batch_module;
      overflow   <= dropped_flag;
    end
    if (state == pscm_pkg::ST_PRE_EMIT) begin
      out_plane     <= 1'b0;
      {out_radius, out_cells, out_adc, out_y, out_x} <= ent;
      pid_flag      <= ent[40:21] > adc_threshold;
      veto_matched  <= matched;
      last_of_batch <= (veto_count == '0) && (idx + 1'b1 == pre_count);
    end
    if (state == pscm_pkg::ST_VETO_EMIT) begin
      out_plane     <= 1'b1;
      {out_radius, out_cells, out_adc, out_y, out_x} <= veto_rdata;
      pid_flag      <= 1'b0;
      veto_matched  <= 1'b0;
      last_of_batch <= (idx + 1'b1 == veto_count);
    end
  end

  pscm_ram #(.WIDTH(pscm_pkg::ENT_W), .DEPTH(pscm_pkg::MAX_CLUSTERS)) u_pre_ram (
    .clk(clk), .we(pre_we), .waddr(pre_count[pscm_pkg::IDX_W-1:0]), .wdata(in_ent),
    .raddr(pre_raddr), .rdata(pre_rdata)
  );

  pscm_ram #(.WIDTH(pscm_pkg::ENT_W), .DEPTH(pscm_pkg::MAX_CLUSTERS)) u_veto_ram (
    .clk(clk), .we(veto_we), .waddr(veto_count[pscm_pkg::IDX_W-1:0]), .wdata(in_ent),
    .raddr(veto_raddr), .rdata(veto_rdata)
  );

  // sort list entries carry their ADC key next to the item index
  pscm_ram #(.WIDTH(pscm_pkg::SORT_W), .DEPTH(pscm_pkg::MAX_CLUSTERS)) u_sort_ram (
    .clk(clk), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
    .raddr(sort_raddr), .rdata(sort_rdata)
  );

  // hit / claim grid, one cell per pad
  pscm_ram #(.WIDTH(2), .DEPTH(pscm_pkg::GRID_CELLS)) u_grid_ram (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_ua), .rdata(grid_rdata)
  );

  `PSCM_ASSERT_NOW(a_result_busy, result_valid, busy)
  `PSCM_ASSERT_NOW(a_last_strobe, last_of_batch && !busy, !result_valid)
  `PSCM_ASSERT_NOW(a_veto_flags, result_valid && out_plane, !pid_flag && !veto_matched)
  `PSCM_ASSERT_NEXT(a_close_busy, accept && last_in_batch, busy)
  `PSCM_ASSERT_NOW(a_probe_range, state == pscm_pkg::ST_PROBE_CHK,
                   k <= 3'(pscm_pkg::NB_LAST))

endmodule
